// File: rtl/core/sxu_pkg.sv
// sxu_pkg: shared types and constants of the subset execute unit
// used by sxu_ctrl, sxu_datapath and the top level; no dependencies
package sxu_pkg;

    // instruction class carried on the input side-band
    typedef enum logic [1:0] {
        CMD_DP  = 2'd0,
        CMD_MUL = 2'd1,
        CMD_LS  = 2'd2,
        CMD_BR  = 2'd3
    } cmd_t;

    // data processing opcodes
    localparam logic [3:0] OP_AND = 4'd0;
    localparam logic [3:0] OP_EOR = 4'd1;
    localparam logic [3:0] OP_SUB = 4'd2;
    localparam logic [3:0] OP_RSB = 4'd3;
    localparam logic [3:0] OP_ADD = 4'd4;
    localparam logic [3:0] OP_TST = 4'd8;
    localparam logic [3:0] OP_TEQ = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_ORR = 4'd12;
    localparam logic [3:0] OP_MOV = 4'd13;

    // shift kinds
    localparam logic [1:0] SH_LSL = 2'd0;
    localparam logic [1:0] SH_LSR = 2'd1;
    localparam logic [1:0] SH_ASR = 2'd2;
    localparam logic [1:0] SH_ROR = 2'd3;

    // register read slots
    localparam logic [1:0] RD_RM = 2'd0;
    localparam logic [1:0] RD_RS = 2'd1;
    localparam logic [1:0] RD_RN = 2'd2;
    localparam logic [1:0] RD_RD = 2'd3;

    localparam logic [3:0] PC_INDEX = 4'd15;

    // controller to datapath commands
    typedef struct packed {
        logic       clr_en;
        logic       latch_in;
        logic       rd_en;
        logic [1:0] rd_sel;
        logic       shift_en;
        logic       alu_en;
        logic       mrd_en;
        logic       mrd_hi;
        logic       cap_lo;
        logic       cap_hi;
        logic       mwr_en;
        logic       mwr_hi;
        logic       wb_main;
        logic       wb_load;
        logic       fin;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic is_ls;
        logic is_load;
        logic fault;
    } dp_status_t;

endpackage

// File: rtl/core/sxu_ctrl.sv
// sxu_ctrl: sequencing state machine of the subset execute unit
// depends on sxu_pkg; drives sxu_datapath through dp_cmd_t
module sxu_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  sxu_pkg::dp_status_t  status,
    output sxu_pkg::dp_cmd_t     cmd
);

    typedef enum logic [15:0] {
        S_CLEAR = 16'b0000_0000_0000_0001,
        S_IDLE  = 16'b0000_0000_0000_0010,
        S_RD0   = 16'b0000_0000_0000_0100,
        S_RD1   = 16'b0000_0000_0000_1000,
        S_RD2   = 16'b0000_0000_0001_0000,
        S_RD3   = 16'b0000_0000_0010_0000,
        S_SHIFT = 16'b0000_0000_0100_0000,
        S_ALU   = 16'b0000_0000_1000_0000,
        S_MRD0  = 16'b0000_0001_0000_0000,
        S_MRD1  = 16'b0000_0010_0000_0000,
        S_MRD2  = 16'b0000_0100_0000_0000,
        S_MWR0  = 16'b0000_1000_0000_0000,
        S_MWR1  = 16'b0001_0000_0000_0000,
        S_WB0   = 16'b0010_0000_0000_0000,
        S_WB1   = 16'b0100_0000_0000_0000,
        S_FIN   = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // next state and command decode
    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg;
        cmd           = '0;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_en = 1'b1;
                if (status.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_RD0;
                end
            end
            S_RD0:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sxu_pkg::RD_RM;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sxu_pkg::RD_RS;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sxu_pkg::RD_RN;
                state_next = S_RD3;
            end
            S_RD3:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = sxu_pkg::RD_RD;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift_en = 1'b1;
                state_next   = S_ALU;
            end
            S_ALU:
            begin
                cmd.alu_en = 1'b1;
                state_next = status.is_ls ? S_MRD0 : S_WB0;
            end
            S_MRD0:
            begin
                cmd.mrd_en = 1'b1;
                state_next = status.fault ? S_WB0 : S_MRD1;
            end
            S_MRD1:
            begin
                cmd.mrd_en = 1'b1;
                cmd.mrd_hi = 1'b1;
                cmd.cap_lo = 1'b1;
                state_next = S_MRD2;
            end
            S_MRD2:
            begin
                cmd.cap_hi = 1'b1;
                state_next = status.is_load ? S_WB0 : S_MWR0;
            end
            S_MWR0:
            begin
                cmd.mwr_en = 1'b1;
                state_next = S_MWR1;
            end
            S_MWR1:
            begin
                cmd.mwr_en = 1'b1;
                cmd.mwr_hi = 1'b1;
                state_next = S_WB0;
            end
            S_WB0:
            begin
                cmd.wb_main = 1'b1;
                state_next  = S_WB1;
            end
            S_WB1:
            begin
                cmd.wb_load = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.fin       = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// File: rtl/core/sxu_datapath.sv
// sxu_datapath: register file, shifter, alu, multiplier and data memory
// depends on sxu_pkg; sequenced by sxu_ctrl
module sxu_datapath #(
    parameter int MEM_WORDS = 16384
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sxu_pkg::dp_cmd_t     cmd,
    output sxu_pkg::dp_status_t  status,
    input  logic [1:0]           in_command,
    input  logic [31:0]          in_instruction,
    output logic                 dest_written,
    output logic [3:0]           dest_index,
    output logic [31:0]          dest_value,
    output logic                 flag_negative,
    output logic                 flag_zero,
    output logic                 flag_carry,
    output logic [31:0]          next_pc,
    output logic                 memory_fault
);

    localparam int          AW         = $clog2(MEM_WORDS);
    localparam logic [31:0] BYTE_LIMIT = 32'(MEM_WORDS * 4);
    localparam logic [AW:0] WORD_LIMIT = (AW + 1)'(MEM_WORDS);
    localparam logic [AW-1:0] LAST_WORD = AW'(MEM_WORDS - 1);

    // state
    logic [31:0]   rf_reg [16];
    logic [2:0]    flags_reg;
    logic [31:0]   mem [MEM_WORDS];
    logic [31:0]   mem_q_reg;
    logic [AW-1:0] clr_cnt_reg;

    // instruction and operands
    logic [1:0]  cmd_reg;
    logic [31:0] ins_reg;
    logic [31:0] rm_reg, rs_reg, rn_reg, rd_reg;
    logic [31:0] op2_reg, prod_reg;
    logic        sc_reg;

    // alu results
    logic        main_wr_reg;
    logic [3:0]  main_idx_reg;
    logic [31:0] main_val_reg;
    logic        nz_upd_reg, c_upd_reg, c_val_reg;
    logic [31:0] addr_reg, st_val_reg;
    logic        fault_reg;
    logic [31:0] q0_reg, q1_reg;

    // reported destination
    logic        rep_wr_reg;
    logic [3:0]  rep_idx_reg;
    logic [31:0] rep_val_reg;
    logic        pc_wr_reg;

    // output register
    logic        o_wr_reg, o_n_reg, o_z_reg, o_c_reg, o_fault_reg;
    logic [3:0]  o_idx_reg;
    logic [31:0] o_val_reg, o_pc_reg;

    // program counter after the instruction
    logic [31:0] pc_next;

    logic        is_dp, is_mul, is_ls, is_br;
    assign is_dp  = (cmd_reg == sxu_pkg::CMD_DP);
    assign is_mul = (cmd_reg == sxu_pkg::CMD_MUL);
    assign is_ls  = (cmd_reg == sxu_pkg::CMD_LS);
    assign is_br  = (cmd_reg == sxu_pkg::CMD_BR);

    assign status.clr_done = (clr_cnt_reg == LAST_WORD);
    assign status.is_ls    = is_ls;
    assign status.is_load  = ins_reg[20];
    assign status.fault    = fault_reg;

    // register read address
    logic [3:0] rd_addr;
    always_comb
    begin
        case (cmd.rd_sel)
            sxu_pkg::RD_RM: rd_addr = ins_reg[3:0];
            sxu_pkg::RD_RS: rd_addr = ins_reg[11:8];
            sxu_pkg::RD_RN: rd_addr = is_mul ? ins_reg[15:12] : ins_reg[19:16];
            sxu_pkg::RD_RD: rd_addr = ins_reg[15:12];
            default:        rd_addr = ins_reg[3:0];
        endcase
    end

    // barrel shifter and immediate rotate
    logic [31:0] sh_val, imm_val, op2_next;
    logic        sh_c, imm_c, sc_next;
    always_comb
    begin
        logic [7:0]  amt8;
        logic [4:0]  amt5, rot;
        logic [63:0] lsl_t, ror_t, z64;
        logic [32:0] lsr_t, asr_t;
        logic        cin;
        amt8  = ins_reg[4] ? rs_reg[7:0] : {3'b000, ins_reg[11:7]};
        amt5  = amt8[4:0];
        cin   = flags_reg[0];
        lsl_t = {32'd0, rm_reg} << amt5;
        lsr_t = {rm_reg, 1'b0} >> amt5;
        asr_t = 33'($signed({rm_reg, 1'b0}) >>> amt5);
        ror_t = {rm_reg, rm_reg} >> amt5;
        sh_val = rm_reg;
        sh_c   = cin;
        if (amt8 != 8'd0)
        begin
            case (ins_reg[6:5])
                sxu_pkg::SH_LSL:
                begin
                    if (amt8 < 8'd32)
                    begin
                        sh_val = lsl_t[31:0];
                        sh_c   = lsl_t[32];
                    end
                    else
                    begin
                        sh_val = 32'd0;
                        sh_c   = (amt8 == 8'd32) ? rm_reg[0] : 1'b0;
                    end
                end
                sxu_pkg::SH_LSR:
                begin
                    if (amt8 < 8'd32)
                    begin
                        sh_val = lsr_t[32:1];
                        sh_c   = lsr_t[0];
                    end
                    else
                    begin
                        sh_val = 32'd0;
                        sh_c   = (amt8 == 8'd32) ? rm_reg[31] : 1'b0;
                    end
                end
                sxu_pkg::SH_ASR:
                begin
                    if (amt8 < 8'd32)
                    begin
                        sh_val = asr_t[32:1];
                        sh_c   = asr_t[0];
                    end
                    else
                    begin
                        sh_val = {32{rm_reg[31]}};
                        sh_c   = rm_reg[31];
                    end
                end
                default:
                begin
                    sh_val = ror_t[31:0];
                    sh_c   = ror_t[31];
                end
            endcase
        end
        rot     = {ins_reg[11:8], 1'b0};
        z64     = {24'd0, ins_reg[7:0], 24'd0, ins_reg[7:0]};
        imm_val = 32'(z64 >> rot);
        imm_c   = (rot != 5'd0) ? imm_val[31] : cin;
        if (is_dp && ins_reg[25])
        begin
            op2_next = imm_val;
            sc_next  = imm_c;
        end
        else if (is_ls && !ins_reg[25])
        begin
            op2_next = {20'd0, ins_reg[11:0]};
            sc_next  = sh_c;
        end
        else
        begin
            op2_next = sh_val;
            sc_next  = sh_c;
        end
    end

    // alu, accumulate and address generation
    logic        a_wr, a_nz, a_cu, a_c, a_fault;
    logic [3:0]  a_idx;
    logic [31:0] a_val, a_addr, a_st;
    always_comb
    begin
        logic [32:0] sum;
        logic [31:0] r, base_addr, wb_val;
        logic        dp_ok;
        logic [3:0]  op;
        op        = ins_reg[24:21];
        r         = 32'd0;
        dp_ok     = 1'b1;
        a_c       = sc_reg;
        sum       = {1'b0, rn_reg} + {1'b0, op2_reg};
        case (op)
            sxu_pkg::OP_AND, sxu_pkg::OP_TST: r = rn_reg & op2_reg;
            sxu_pkg::OP_EOR, sxu_pkg::OP_TEQ: r = rn_reg ^ op2_reg;
            sxu_pkg::OP_ORR:                  r = rn_reg | op2_reg;
            sxu_pkg::OP_MOV:                  r = op2_reg;
            sxu_pkg::OP_SUB, sxu_pkg::OP_CMP:
            begin
                r   = rn_reg - op2_reg;
                a_c = (rn_reg >= op2_reg);
            end
            sxu_pkg::OP_RSB:
            begin
                r   = op2_reg - rn_reg;
                a_c = (op2_reg >= rn_reg);
            end
            sxu_pkg::OP_ADD:
            begin
                r   = sum[31:0];
                a_c = sum[32];
            end
            default: dp_ok = 1'b0;
        endcase
        base_addr = (ins_reg[19:16] == sxu_pkg::PC_INDEX)
                    ? ({rn_reg[29:0], 2'b00} + 32'd4) : rn_reg;
        wb_val    = ins_reg[23] ? (rn_reg + op2_reg) : (rn_reg - op2_reg);
        if (ins_reg[24])
        begin
            a_addr = ins_reg[23] ? (base_addr + op2_reg) : (base_addr - op2_reg);
        end
        else
        begin
            a_addr = base_addr;
        end
        a_st    = (!ins_reg[24] && (ins_reg[15:12] == ins_reg[19:16])) ? wb_val : rd_reg;
        a_fault = 1'b0;
        a_wr    = 1'b0;
        a_idx   = ins_reg[15:12];
        a_val   = r;
        a_nz    = 1'b0;
        a_cu    = 1'b0;
        case (cmd_reg)
            sxu_pkg::CMD_DP:
            begin
                a_wr = dp_ok && !(op == sxu_pkg::OP_TST || op == sxu_pkg::OP_TEQ
                                  || op == sxu_pkg::OP_CMP);
                a_nz = dp_ok && ins_reg[20];
                a_cu = dp_ok && ins_reg[20];
            end
            sxu_pkg::CMD_MUL:
            begin
                a_wr  = 1'b1;
                a_idx = ins_reg[19:16];
                a_val = prod_reg + (ins_reg[21] ? rn_reg : 32'd0);
                a_nz  = ins_reg[20];
            end
            sxu_pkg::CMD_LS:
            begin
                a_wr    = !ins_reg[24];
                a_idx   = ins_reg[19:16];
                a_val   = wb_val;
                a_fault = (a_addr >= BYTE_LIMIT);
            end
            default:
            begin
                a_wr = 1'b0;
            end
        endcase
    end

    // memory word addresses and byte lane merge
    logic [AW-1:0] w0, w1;
    logic [AW:0]   w1_full;
    logic          w1_ok;
    logic [5:0]    lane_sh;
    logic [63:0]   comb64, new64;
    logic [31:0]   ld_val;
    assign w0      = addr_reg[AW+1:2];
    assign w1_full = {1'b0, w0} + (AW + 1)'(1);
    assign w1_ok   = (w1_full < WORD_LIMIT);
    assign w1      = w1_full[AW-1:0];
    assign lane_sh = {addr_reg[1:0], 3'b000};
    assign comb64  = {(w1_ok ? q1_reg : 32'd0), q0_reg};
    assign ld_val  = 32'(comb64 >> lane_sh);
    assign new64   = (comb64 & ~(64'h0000_0000_FFFF_FFFF << lane_sh))
                   | ({32'd0, st_val_reg} << lane_sh);

    // data memory port
    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [31:0]   mem_wd;
    assign mem_we = cmd.clr_en || (cmd.mwr_en && (!cmd.mwr_hi || w1_ok));
    assign mem_wa = cmd.clr_en ? clr_cnt_reg : (cmd.mwr_hi ? w1 : w0);
    assign mem_wd = cmd.clr_en ? 32'd0 : (cmd.mwr_hi ? new64[63:32] : new64[31:0]);
    assign mem_ra = cmd.mrd_hi ? w1 : w0;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.mrd_en)
        begin
            mem_q_reg <= mem[mem_ra];
        end
    end

    // clearing pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_en && !status.clr_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    // payload pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            cmd_reg <= in_command;
            ins_reg <= in_instruction;
        end
        if (cmd.rd_en)
        begin
            case (cmd.rd_sel)
                sxu_pkg::RD_RM: rm_reg <= rf_reg[rd_addr];
                sxu_pkg::RD_RS: rs_reg <= rf_reg[rd_addr];
                sxu_pkg::RD_RN: rn_reg <= rf_reg[rd_addr];
                default:        rd_reg <= rf_reg[rd_addr];
            endcase
        end
        if (cmd.shift_en)
        begin
            op2_reg  <= op2_next;
            sc_reg   <= sc_next;
            prod_reg <= rm_reg * rs_reg;
        end
        if (cmd.alu_en)
        begin
            main_wr_reg  <= a_wr;
            main_idx_reg <= a_idx;
            main_val_reg <= a_val;
            nz_upd_reg   <= a_nz;
            c_upd_reg    <= a_cu;
            c_val_reg    <= a_c;
            addr_reg     <= a_addr;
            st_val_reg   <= a_st;
        end
        if (cmd.cap_lo)
        begin
            q0_reg <= mem_q_reg;
        end
        if (cmd.cap_hi)
        begin
            q1_reg <= mem_q_reg;
        end
        if (cmd.fin)
        begin
            o_wr_reg    <= rep_wr_reg;
            o_idx_reg   <= rep_idx_reg;
            o_val_reg   <= rep_val_reg;
            o_n_reg     <= flags_reg[2];
            o_z_reg     <= flags_reg[1];
            o_c_reg     <= flags_reg[0];
            o_fault_reg <= fault_reg;
            o_pc_reg    <= pc_next;
        end
    end

    // branch target, written pc or plain advance
    always_comb
    begin
        if (is_br)
        begin
            pc_next = rf_reg[15] + {{8{ins_reg[23]}}, ins_reg[23:0]} + 32'd1;
        end
        else if (pc_wr_reg)
        begin
            pc_next = rf_reg[15];
        end
        else
        begin
            pc_next = rf_reg[15] + 32'd1;
        end
    end

    logic load_ok;
    assign load_ok = is_ls && ins_reg[20] && !fault_reg;

    // architectural state: register file, flags, writeback report
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                rf_reg[i] <= 32'd0;
            end
            flags_reg   <= 3'd0;
            fault_reg   <= 1'b0;
            rep_wr_reg  <= 1'b0;
            rep_idx_reg <= 4'd0;
            rep_val_reg <= 32'd0;
            pc_wr_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.alu_en)
            begin
                fault_reg <= a_fault;
            end
            if (cmd.wb_main)
            begin
                rep_wr_reg  <= main_wr_reg;
                rep_idx_reg <= main_wr_reg ? main_idx_reg : 4'd0;
                rep_val_reg <= main_wr_reg ? main_val_reg : 32'd0;
                pc_wr_reg   <= main_wr_reg && (main_idx_reg == sxu_pkg::PC_INDEX);
                if (main_wr_reg)
                begin
                    rf_reg[main_idx_reg] <= main_val_reg;
                end
                if (nz_upd_reg)
                begin
                    flags_reg[2] <= main_val_reg[31];
                    flags_reg[1] <= (main_val_reg == 32'd0);
                end
                if (c_upd_reg)
                begin
                    flags_reg[0] <= c_val_reg;
                end
            end
            if (cmd.wb_load && load_ok)
            begin
                rf_reg[ins_reg[15:12]] <= ld_val;
                rep_wr_reg  <= 1'b1;
                rep_idx_reg <= ins_reg[15:12];
                rep_val_reg <= ld_val;
                if (ins_reg[15:12] == sxu_pkg::PC_INDEX)
                begin
                    pc_wr_reg <= 1'b1;
                end
            end
            if (cmd.fin)
            begin
                rf_reg[15] <= pc_next;
            end
        end
    end

    assign dest_written  = o_wr_reg;
    assign dest_index    = o_idx_reg;
    assign dest_value    = o_val_reg;
    assign flag_negative = o_n_reg;
    assign flag_zero     = o_z_reg;
    assign flag_carry    = o_c_reg;
    assign next_pc       = o_pc_reg;
    assign memory_fault  = o_fault_reg;

endmodule

// File: rtl/core/arm_subset_execute_unit_core.sv
// Sequence: register reads, shift, alu, writeback and result for data processing,
// multiply and branch; a load/store adds memory reads (cut short on a fault) and
// a store memory writes. One instruction at a time; the next can be accepted from the
// cycle in which the result is offered, and a result still held stalls the unit.
// Reset: rst_n clears the register file and flags, then a clearing pass writes zero to
// every data memory word, with s_tready held low.
module arm_subset_execute_unit_core #(
    parameter int MEM_WORDS = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] instruction
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [3:0] dest_index, [35:4] dest_value,
                                   // [36] flag_negative, [37] flag_zero,
                                   // [38] flag_carry, [70:39] next_pc,
                                   // [71] memory_fault
    output logic        m_tuser    // [0] dest_written
);

    sxu_pkg::dp_cmd_t    cmd;
    sxu_pkg::dp_status_t status;

    logic        dest_written, flag_negative, flag_zero, flag_carry, memory_fault;
    logic [3:0]  dest_index;
    logic [31:0] dest_value, next_pc;

    // sequencer
    sxu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // execution datapath
    sxu_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_command     (s_tuser),
        .in_instruction (s_tdata),
        .dest_written   (dest_written),
        .dest_index     (dest_index),
        .dest_value     (dest_value),
        .flag_negative  (flag_negative),
        .flag_zero      (flag_zero),
        .flag_carry     (flag_carry),
        .next_pc        (next_pc),
        .memory_fault   (memory_fault)
    );

    // result packing
    assign m_tdata = {memory_fault, next_pc, flag_carry, flag_zero, flag_negative,
                      dest_value, dest_index};
    assign m_tuser = dest_written;

endmodule

// File: rtl/core/sxu_checker.sv
// sxu_checker: port-level assertions for arm_subset_execute_unit_core
// attached by the bind statement at the end of this file
module sxu_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata,
    input logic        m_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // one instruction in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second transaction accepted while busy");

    // a new result appears only after the unit was busy
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without prior execution");

    // no destination reported means index and value are zero
    a_no_dest: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata[35:0] == 36'd0))
        else $error("destination fields set without write");

endmodule

bind arm_subset_execute_unit_core sxu_checker u_sxu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
